@@ hw/rtl/rtpts_pkg.sv @@
// Shared constants, types and functions for the RTP video timestamp generator.
package rtpts_pkg;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_START_TS = 1'b0,
    REG_INIT_FI  = 1'b1
  } cfg_reg_t;

  // Tick conversion pipeline depth ahead of the state update
  localparam int NSTG = 6;

  // Frame interval after reset and the largest step learned as an interval
  localparam logic [31:0] FI_RESET   = 32'd3000;
  localparam logic [31:0] STEP_LIMIT = 32'd9000;

  // ticks = floor(floor(9*ns / 32) / 3125); 3125 is odd, so the quotient mod 2^32
  // is (N - N mod 3125) times the inverse of 3125 mod 2^32
  localparam logic [12:0] RES_MOD = 13'd3125;

  // Residues of the 16-bit chunk weights 2^16, 2^32, 2^48 mod 3125
  localparam logic [11:0] K1 = 12'(((64'd1) << 16) % 64'd3125);
  localparam logic [11:0] K2 = 12'(((64'd1) << 32) % 64'd3125);
  localparam logic [11:0] K3 = 12'(((64'd1) << 48) % 64'd3125);

  // Reciprocal of 3125 for residues below 2^29: estimate is exact or one low
  localparam int          RECIP_SH = 40;
  localparam logic [28:0] RECIP_M  = 29'(((64'd1) << RECIP_SH) / 64'd3125);

  // Inverse of an odd value mod 2^32 by Newton steps (precision doubles each step)
  function automatic logic [31:0] inv_mod32(input logic [31:0] a);
    logic [31:0] x;
    x = a;
    for (int i = 0; i < 4; i++) begin
      x = x * (32'd2 - a * x);
    end
    return x;
  endfunction

  localparam logic [31:0] INV_MOD = inv_mod32(32'd3125);

endpackage

@@ hw/rtl/rtp_video_timestamp_generator_top.sv @@
// Top level of the RTP video timestamp generator: tick pipeline and timeline state.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one word per encoded video unit:
//   generation number, PTS-present flag and PTS in nanoseconds. The result
//   channel (out_valid / out_stall) returns one 32-bit 90 kHz RTP timestamp
//   per input word, in order.
//   From acceptance to out_valid, six stages convert the PTS to ticks
//   (scale, residue sum, reciprocal multiply, residue estimate, residue
//   fix and subtract, inverse multiply), then the timeline state updates
//   as the word enters the output register. One word per cycle is sustained
//   while out_stall is low; the state update loops at the output register.
//   A stalled output holds its word; earlier stages keep filling bubbles, and
//   in_stall rises only when every stage and the output register hold a word
//   while the output is stalled.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready;
//   write it only while no word is in flight. Writing the initial frame
//   interval also loads the working frame interval.
//   Synchronous reset clears all words in flight and the timeline state, sets
//   the start timestamp to 0 and the frame interval to 3000 ticks.
module rtp_video_timestamp_generator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [31:0]                 in_generation,
  input  logic                        in_has_pts,
  input  logic [63:0]                 in_pts_ns,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [31:0]                 out_rtp_timestamp,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  rtpts_pkg::cfg_reg_t         cfg_index,
  input  logic [31:0]                 cfg_data
);

  localparam int NSTG = rtpts_pkg::NSTG;

  // Pipeline control and carried fields
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] rdy;
  logic            rdy_out;
  logic [31:0]     gen_r [NSTG];
  logic            has_r [NSTG];

  // Stage payloads
  logic [67:0] ns9;
  logic [62:0] n_r;
  logic [28:0] s_nxt, s_r, s2_r;
  logic [31:0] nlo1_r, nlo2_r, nlo3_r;
  logic [57:0] prod_r;
  logic [12:0] rest_nxt, rest_r, res_fix;
  logic [31:0] dsub_r, ticks_r;

  // Timeline state
  logic [31:0] start_ts_r;
  logic [31:0] fi_r, fi_nxt;
  logic [31:0] last_gen_r;
  logic        have_out_r;
  logic [31:0] last_out_r;
  logic        pvalid_r;
  logic [31:0] prev_ticks_r;
  logic [31:0] offset_r, offset_nxt;
  logic        out_valid_r;
  logic [31:0] out_ts_r, out_ts_nxt;

  logic        upd;
  logic        cfg_wr;
  logic        gen_chg;
  logic        pvalid_eff;
  logic        relearn;
  logic [31:0] base_ts;
  logic [31:0] step;

  assign cfg_ready         = 1'b1;
  assign cfg_wr            = cfg_valid && cfg_ready;
  assign out_valid         = out_valid_r;
  assign out_rtp_timestamp = out_ts_r;

  // Ready chain: a stage loads when it is empty or its successor moves on
  always_comb begin
    rdy_out      = !out_valid_r || !out_stall;
    rdy[NSTG-1]  = !v_r[NSTG-1] || rdy_out;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];

  // Advance valid bits and carried fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      gen_r[0] <= in_generation;
      has_r[0] <= in_has_pts;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (rdy[k]) begin
        gen_r[k] <= gen_r[k-1];
        has_r[k] <= has_r[k-1];
      end
    end
  end

  // Stage 0: scale by 9 and drop the power-of-two part of 100000
  assign ns9 = {4'd0, in_pts_ns} + {1'b0, in_pts_ns, 3'd0};

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      n_r <= ns9[67:5];
    end
  end

  // Stage 1: fold 16-bit chunks by their weights mod 3125
  assign s_nxt = 29'(n_r[15:0])
               + 29'(n_r[31:16]) * 29'(rtpts_pkg::K1)
               + 29'(n_r[47:32]) * 29'(rtpts_pkg::K2)
               + 29'(n_r[62:48]) * 29'(rtpts_pkg::K3);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s_r    <= s_nxt;
      nlo1_r <= n_r[31:0];
    end
  end

  // Stage 2: reciprocal multiply for the residue quotient
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      prod_r <= 58'(s_r) * 58'(rtpts_pkg::RECIP_M);
      s2_r   <= s_r;
      nlo2_r <= nlo1_r;
    end
  end

  // Stage 3: residue estimate, below twice the modulus
  assign rest_nxt = 13'(s2_r - 29'(prod_r[57:rtpts_pkg::RECIP_SH]) * 29'(rtpts_pkg::RES_MOD));

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      rest_r <= rest_nxt;
      nlo3_r <= nlo2_r;
    end
  end

  // Stage 4: fix the residue and remove it from the low word
  assign res_fix = (rest_r >= rtpts_pkg::RES_MOD) ? (rest_r - rtpts_pkg::RES_MOD) : rest_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      dsub_r <= nlo3_r - {19'd0, res_fix};
    end
  end

  // Stage 5: exact division by 3125 via the modular inverse
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      ticks_r <= dsub_r * rtpts_pkg::INV_MOD;
    end
  end

  // Timeline update for the word entering the output register
  assign upd        = rdy_out && v_r[NSTG-1];
  assign gen_chg    = have_out_r && (gen_r[NSTG-1] != last_gen_r);
  assign pvalid_eff = pvalid_r && !gen_chg;
  assign base_ts    = have_out_r ? (last_out_r + fi_r) : start_ts_r;
  assign relearn    = have_out_r && !pvalid_eff;
  assign step       = ticks_r - prev_ticks_r;

  always_comb begin
    offset_nxt = offset_r;
    fi_nxt     = fi_r;
    out_ts_nxt = base_ts;
    if (has_r[NSTG-1]) begin
      if (relearn) begin
        offset_nxt = base_ts - ticks_r;
        out_ts_nxt = base_ts;
      end else begin
        if (pvalid_eff && (step != 32'd0) && (step <= rtpts_pkg::STEP_LIMIT)) begin
          fi_nxt = step;
        end
        out_ts_nxt = ticks_r + offset_r;
      end
    end
  end

  // Hold timeline state; take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_ts_r   <= '0;
      fi_r         <= rtpts_pkg::FI_RESET;
      last_gen_r   <= '0;
      have_out_r   <= 1'b0;
      last_out_r   <= '0;
      pvalid_r     <= 1'b0;
      prev_ticks_r <= '0;
      offset_r     <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        rtpts_pkg::REG_START_TS: start_ts_r <= cfg_data;
        rtpts_pkg::REG_INIT_FI:  fi_r       <= cfg_data;
        default: ;
      endcase
    end else if (upd) begin
      last_gen_r <= gen_r[NSTG-1];
      have_out_r <= 1'b1;
      last_out_r <= out_ts_nxt;
      offset_r   <= offset_nxt;
      fi_r       <= fi_nxt;
      if (has_r[NSTG-1]) begin
        prev_ticks_r <= ticks_r;
        pvalid_r     <= 1'b1;
      end else begin
        pvalid_r     <= pvalid_eff;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_out) begin
      out_valid_r <= v_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      out_ts_r <= out_ts_nxt;
    end
  end

  // An accepted word always lands in the first stage
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[0])
    else $error("accepted word did not enter the first stage");

  // Input is never stalled while the first stage is free
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[0] |-> !in_stall)
    else $error("input stalled with an empty first stage");

  // Learned frame interval stays within the step window
  a_fi_window: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(fi_r) && !$past(cfg_wr))
      |-> (fi_r != 32'd0 && fi_r <= rtpts_pkg::STEP_LIMIT))
    else $error("frame interval learned outside the step window");

  // A delivered PTS word leaves a remembered PTS behind
  a_pts_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && has_r[NSTG-1] && !cfg_wr) |=> pvalid_r)
    else $error("PTS word did not set the previous-PTS flag");

endmodule
